### sv/cumhist_pkg.sv
// Shared types and constants for the cumulative histogram block.
// Used by every module of the block except cumhist_ram; depends on nothing else.
package cumhist_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int COUNT_BITS_DEF  = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int IN_COUNT_W = 32;
  localparam int BIN_IDX_W  = 6;
  localparam int VAL_W      = 40;
  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DESCENDING     = 2'd0,
    CFG_NORMALIZE      = 2'd1,
    CFG_CONTAINED_ONLY = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic descending;
    logic normalize;
    logic contained_only;
  } cfg_t;

  typedef struct packed {
    logic [IN_COUNT_W-1:0] bin_count;
    logic                  last_bin;
  } in_item_t;

  typedef struct packed {
    logic [BIN_IDX_W-1:0] bin_index;
    logic [VAL_W-1:0]     cum_value;
    logic                 is_last;
    logic                 edge_ignored;
    logic                 zero_total;
    logic                 truncated;
  } out_item_t;

endpackage

### sv/cumulative_histogram.sv
// Loading accepts one bin word per cycle while in_full is low. Emission of a run starts once
// its summary is queued and the emission side is idle; each bin passes through a store read,
// accumulation, for normalized bins one divider step per quotient bit, and a queue write.
// The bin store has two banks, so a second histogram loads while the first is emitted.
// Synchronous reset clears configuration to its defaults, the run counters, queue pointers
// and sequencer state; the bin store is not cleared, as only current-run words are read.
module cumulative_histogram
  import cumhist_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  in_item_t             in_data,
  output logic                 in_full,
  output logic                 out_empty,
  input  logic                 out_pop,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W = COUNT_BITS + IDX_W;

  cfg_t cfg_r, cfg_nxt;

  logic                  ram_wr_en, ram_rd_en;
  logic [IDX_W:0]        ram_wr_addr, ram_rd_addr;
  logic [COUNT_BITS-1:0] ram_wr_data, ram_rd_data;
  logic                  desc_valid, desc_pop, desc_ovf, desc_bank;
  logic [CNT_W-1:0]      desc_n;
  logic [SUM_W-1:0]      desc_total;
  logic [COUNT_BITS-1:0] desc_first, desc_last;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DESCENDING:     cfg_nxt.descending     = cfg_wdata;
        CFG_NORMALIZE:      cfg_nxt.normalize      = cfg_wdata;
        CFG_CONTAINED_ONLY: cfg_nxt.contained_only = cfg_wdata;
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{descending: 1'b0, normalize: 1'b1, contained_only: 1'b0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cumhist_front #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_data    (in_data),
    .in_full    (in_full),
    .ram_wr_en  (ram_wr_en),
    .ram_wr_addr(ram_wr_addr),
    .ram_wr_data(ram_wr_data),
    .desc_valid (desc_valid),
    .desc_n     (desc_n),
    .desc_total (desc_total),
    .desc_first (desc_first),
    .desc_last  (desc_last),
    .desc_ovf   (desc_ovf),
    .desc_bank  (desc_bank),
    .desc_pop   (desc_pop)
  );

  cumhist_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(2 ** (IDX_W + 1))
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  cumhist_back #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .desc_valid (desc_valid),
    .desc_n     (desc_n),
    .desc_total (desc_total),
    .desc_first (desc_first),
    .desc_last  (desc_last),
    .desc_ovf   (desc_ovf),
    .desc_bank  (desc_bank),
    .desc_pop   (desc_pop),
    .ram_rd_en  (ram_rd_en),
    .ram_rd_addr(ram_rd_addr),
    .ram_rd_data(ram_rd_data),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data)
  );

endmodule

### sv/cumhist_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; no package dependencies.
module cumhist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/cumhist_front.sv
// Load side: accepts bin words, writes them into the current bank of the bin store,
// keeps run totals and queues one run summary per histogram. Depends on cumhist_pkg.
module cumhist_front
  import cumhist_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_ENTRIES),
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1),
  localparam int SUM_W = COUNT_BITS + IDX_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  in_item_t              in_data,
  output logic                  in_full,
  output logic                  ram_wr_en,
  output logic [IDX_W:0]        ram_wr_addr,
  output logic [COUNT_BITS-1:0] ram_wr_data,
  output logic                  desc_valid,
  output logic [CNT_W-1:0]      desc_n,
  output logic [SUM_W-1:0]      desc_total,
  output logic [COUNT_BITS-1:0] desc_first,
  output logic [COUNT_BITS-1:0] desc_last,
  output logic                  desc_ovf,
  output logic                  desc_bank,
  input  logic                  desc_pop
);

  logic                  bank_r, bank_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [COUNT_BITS-1:0] first_r, last_r;

  logic [CNT_W-1:0]      qn_r     [2];
  logic [SUM_W-1:0]      qtot_r   [2];
  logic [COUNT_BITS-1:0] qfirst_r [2];
  logic [COUNT_BITS-1:0] qlast_r  [2];
  logic                  qovf_r   [2];
  logic                  qbank_r  [2];
  logic                  qwp_r, qrp_r;
  logic [1:0]            qcnt_r, qcnt_nxt;

  logic                  accept, close, stored;
  logic [COUNT_BITS-1:0] cnt_in, run_first, run_last;
  logic [CNT_W-1:0]      run_cnt;
  logic [SUM_W-1:0]      run_sum;
  logic                  run_ovf;

  always_comb begin
    in_full   = (qcnt_r == 2'd2);
    accept    = in_push && !in_full;
    close     = accept && in_data.last_bin;
    cnt_in    = COUNT_BITS'(in_data.bin_count);
    stored    = (cnt_r < CNT_W'(MAX_ENTRIES));
    run_cnt   = stored ? cnt_r + CNT_W'(1) : cnt_r;
    run_sum   = stored ? sum_r + SUM_W'(cnt_in) : sum_r;
    run_first = (cnt_r == '0) ? cnt_in : first_r;
    run_last  = stored ? cnt_in : last_r;
    run_ovf   = ovf_r | !stored;

    bank_nxt = bank_r;
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    ovf_nxt  = ovf_r;
    if (accept) begin
      if (close) begin
        bank_nxt = !bank_r;
        cnt_nxt  = '0;
        sum_nxt  = '0;
        ovf_nxt  = 1'b0;
      end else begin
        cnt_nxt = run_cnt;
        sum_nxt = run_sum;
        ovf_nxt = run_ovf;
      end
    end

    qcnt_nxt = qcnt_r + {1'b0, close} - {1'b0, desc_pop};

    ram_wr_en   = accept && stored;
    ram_wr_addr = {bank_r, cnt_r[IDX_W-1:0]};
    ram_wr_data = cnt_in;

    desc_valid = (qcnt_r != 2'd0);
    desc_n     = qn_r[qrp_r];
    desc_total = qtot_r[qrp_r];
    desc_first = qfirst_r[qrp_r];
    desc_last  = qlast_r[qrp_r];
    desc_ovf   = qovf_r[qrp_r];
    desc_bank  = qbank_r[qrp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
      cnt_r  <= '0;
      sum_r  <= '0;
      ovf_r  <= 1'b0;
      qwp_r  <= 1'b0;
      qrp_r  <= 1'b0;
      qcnt_r <= 2'd0;
    end else begin
      bank_r <= bank_nxt;
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
      ovf_r  <= ovf_nxt;
      qcnt_r <= qcnt_nxt;
      if (close) begin
        qwp_r <= !qwp_r;
      end
      if (desc_pop) begin
        qrp_r <= !qrp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_r <= run_first;
      last_r  <= run_last;
    end
    if (close) begin
      qn_r[qwp_r]     <= run_cnt;
      qtot_r[qwp_r]   <= run_sum;
      qfirst_r[qwp_r] <= run_first;
      qlast_r[qwp_r]  <= run_last;
      qovf_r[qwp_r]   <= run_ovf;
      qbank_r[qwp_r]  <= bank_r;
    end
  end

endmodule

### sv/cumhist_back.sv
// Emission side: walks one stored run in summation order, accumulates, when normalizing
// divides by the total one quotient bit per cycle and queues result words. Depends on cumhist_pkg.
module cumhist_back
  import cumhist_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_ENTRIES),
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1),
  localparam int SUM_W = COUNT_BITS + IDX_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  desc_valid,
  input  logic [CNT_W-1:0]      desc_n,
  input  logic [SUM_W-1:0]      desc_total,
  input  logic [COUNT_BITS-1:0] desc_first,
  input  logic [COUNT_BITS-1:0] desc_last,
  input  logic                  desc_ovf,
  input  logic                  desc_bank,
  output logic                  desc_pop,
  output logic                  ram_rd_en,
  output logic [IDX_W:0]        ram_rd_addr,
  input  logic [COUNT_BITS-1:0] ram_rd_data,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_item_t             out_data
);

  localparam int DC_W  = $clog2(FRAC_BITS + 1);
  localparam int CMP_W = (SUM_W > VAL_W) ? SUM_W : VAL_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_ACC  = 5'b00100,
    S_DIV  = 5'b01000,
    S_PUT  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [SUM_W-1:0]     tot_r, tot_nxt;
  logic [SUM_W-1:0]     run_r, run_nxt;
  logic                 edge_r, edge_nxt;
  logic                 zt_r, zt_nxt;
  logic [IDX_W-1:0]     k_r, k_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [SUM_W:0]       rem_r, rem_nxt;
  logic [FRAC_BITS:0]   q_r, q_nxt;
  logic [DC_W-1:0]      dcnt_r, dcnt_nxt;
  logic [VAL_W-1:0]     val_r, val_nxt;

  out_item_t            of_r [2];
  logic                 of_wp_r, of_rp_r;
  logic [1:0]           of_cnt_r;

  logic [IDX_W-1:0]     lastidx, idx_sel;
  logic [SUM_W-1:0]     edge_sum, tot_use, acc;
  logic [SUM_W-1:0]     diff;
  logic                 ge, is_edge, of_push, of_full, of_take;
  logic [CMP_W-1:0]     acc_ext;
  out_item_t            item;

  always_comb begin
    lastidx  = IDX_W'(desc_n - CNT_W'(1));
    idx_sel  = cfg.descending ? lastidx - k_r : k_r;
    edge_sum = SUM_W'(desc_first) + SUM_W'(desc_last);
    if (!cfg.contained_only) begin
      tot_use = desc_total;
    end else if (desc_n == CNT_W'(1)) begin
      tot_use = '0;
    end else begin
      tot_use = desc_total - edge_sum;
    end

    is_edge = (idx_r == '0) || (idx_r == lastidx);
    acc     = run_r + SUM_W'(ram_rd_data);
    acc_ext = CMP_W'(acc);

    ge   = (rem_r >= {1'b0, tot_r});
    diff = ge ? SUM_W'(rem_r - {1'b0, tot_r}) : SUM_W'(rem_r);

    of_full = (of_cnt_r == 2'd2);
    of_take = out_pop && (of_cnt_r != 2'd0);

    item.bin_index    = BIN_IDX_W'(idx_r);
    item.cum_value    = val_r;
    item.is_last      = (k_r == lastidx);
    item.edge_ignored = edge_r;
    item.zero_total   = zt_r;
    item.truncated    = desc_ovf;

    state_nxt = state_r;
    tot_nxt   = tot_r;
    run_nxt   = run_r;
    edge_nxt  = edge_r;
    zt_nxt    = zt_r;
    k_nxt     = k_r;
    idx_nxt   = idx_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    dcnt_nxt  = dcnt_r;
    val_nxt   = val_r;
    ram_rd_en = 1'b0;
    of_push   = 1'b0;
    desc_pop  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (desc_valid) begin
          tot_nxt   = tot_use;
          edge_nxt  = cfg.contained_only && ((desc_first != '0) || (desc_last != '0));
          zt_nxt    = cfg.normalize && (tot_use == '0);
          run_nxt   = '0;
          k_nxt     = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        ram_rd_en = 1'b1;
        idx_nxt   = idx_sel;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (cfg.contained_only && is_edge) begin
          val_nxt   = '0;
          state_nxt = S_PUT;
        end else begin
          run_nxt = acc;
          if (!cfg.normalize) begin
            val_nxt   = (acc_ext > CMP_W'(VAL_MAX)) ? VAL_MAX : VAL_W'(acc_ext);
            state_nxt = S_PUT;
          end else if (zt_r) begin
            val_nxt   = '0;
            state_nxt = S_PUT;
          end else begin
            rem_nxt   = {1'b0, acc};
            q_nxt     = '0;
            dcnt_nxt  = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_nxt  = {diff, 1'b0};
        q_nxt    = {q_r[FRAC_BITS-1:0], ge};
        dcnt_nxt = dcnt_r + DC_W'(1);
        if (dcnt_r == DC_W'(FRAC_BITS)) begin
          val_nxt   = VAL_W'(q_nxt);
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        if (!of_full) begin
          of_push = 1'b1;
          if (k_r == lastidx) begin
            desc_pop  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    ram_rd_addr = {desc_bank, idx_sel};
    out_empty   = (of_cnt_r == 2'd0);
    out_data    = of_r[of_rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      of_wp_r  <= 1'b0;
      of_rp_r  <= 1'b0;
      of_cnt_r <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      of_cnt_r <= of_cnt_r + {1'b0, of_push} - {1'b0, of_take};
      if (of_push) begin
        of_wp_r <= !of_wp_r;
      end
      if (of_take) begin
        of_rp_r <= !of_rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    tot_r  <= tot_nxt;
    run_r  <= run_nxt;
    edge_r <= edge_nxt;
    zt_r   <= zt_nxt;
    k_r    <= k_nxt;
    idx_r  <= idx_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    dcnt_r <= dcnt_nxt;
    val_r  <= val_nxt;
    if (of_push) begin
      of_r[of_wp_r] <= item;
    end
  end

  a_ofifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    of_cnt_r != 2'd3)
    else $error("Result queue count out of range.");

  a_run_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (of_push && item.is_last) |=> (state_r == S_IDLE))
    else $error("Sequencer did not return to idle after the final word of a run.");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && dcnt_r == DC_W'(FRAC_BITS)) |=> (state_r == S_PUT))
    else $error("Divider did not finish after the expected number of steps.");

  a_pop_has_run: assert property (@(posedge clk) disable iff (!rst_n)
    desc_pop |-> (desc_valid && state_r == S_PUT))
    else $error("Run summary released without a pending run.");

endmodule
